[design/vsd_pkg.sv]
// shared types and constants for the varint stream decoder
package vsd_pkg;

    // prefix bytes that announce a multi-byte integer
    localparam logic [7:0] PREFIX_TWO  = 8'hfd;
    localparam logic [7:0] PREFIX_FOUR = 8'hfe;

    // payload byte counts and full encoded lengths per prefix
    localparam logic [3:0] PAYLOAD_TWO   = 4'd2;
    localparam logic [3:0] PAYLOAD_FOUR  = 4'd4;
    localparam logic [3:0] PAYLOAD_EIGHT = 4'd8;
    localparam logic [3:0] LENGTH_ONE    = 4'd1;
    localparam logic [3:0] LENGTH_THREE  = 4'd3;
    localparam logic [3:0] LENGTH_FIVE   = 4'd5;
    localparam logic [3:0] LENGTH_NINE   = 4'd9;

    // status codes
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    // output data bus width: 64 value bits plus 4 length bits, padded to bytes
    localparam int OUT_DATA_W = 72;

    // decoder state carried from byte to byte
    typedef struct packed {
        logic [63:0] accumulator;
        logic [3:0]  bytes_remaining;
        logic [3:0]  total_length;
    } t_state;

    // one decoded result
    typedef struct packed {
        logic [63:0] decoded_value;
        logic [3:0]  encoded_length;
        logic        status;
    } t_result;

endpackage

[design/vsd_step.sv]
// next-state and result logic for one input byte
module vsd_step
    import vsd_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_buffer,
    output t_state      o_state,
    output logic        o_emit,
    output t_result     o_result
);

    logic [63:0] shifted;
    logic [3:0]  remaining_dec;

    assign shifted       = {i_state.accumulator[55:0], i_data_byte};
    assign remaining_dec = i_state.bytes_remaining - 4'd1;

    // decode one byte against the current state
    always_comb begin
        o_state  = '0;
        o_emit   = 1'b0;
        o_result = '0;
        if (i_state.bytes_remaining == 4'd0) begin
            if (i_data_byte < PREFIX_TWO) begin
                // single-byte integer
                o_emit                  = 1'b1;
                o_result.decoded_value  = {56'd0, i_data_byte};
                o_result.encoded_length = LENGTH_ONE;
                o_result.status         = STATUS_OK;
            end else if (i_end_of_buffer) begin
                // prefix arrives as the last byte of the buffer
                o_emit          = 1'b1;
                o_result.status = STATUS_TRUNCATED;
            end else begin
                // prefix: start a fresh payload
                case (i_data_byte)
                    PREFIX_TWO: begin
                        o_state.bytes_remaining = PAYLOAD_TWO;
                        o_state.total_length    = LENGTH_THREE;
                    end
                    PREFIX_FOUR: begin
                        o_state.bytes_remaining = PAYLOAD_FOUR;
                        o_state.total_length    = LENGTH_FIVE;
                    end
                    default: begin
                        o_state.bytes_remaining = PAYLOAD_EIGHT;
                        o_state.total_length    = LENGTH_NINE;
                    end
                endcase
            end
        end else if (remaining_dec == 4'd0) begin
            // last payload byte completes the integer
            o_emit                  = 1'b1;
            o_result.decoded_value  = shifted;
            o_result.encoded_length = i_state.total_length;
            o_result.status         = STATUS_OK;
        end else if (i_end_of_buffer) begin
            // buffer ends inside the payload
            o_emit          = 1'b1;
            o_result.status = STATUS_TRUNCATED;
        end else begin
            // keep gathering payload bytes
            o_state.accumulator     = shifted;
            o_state.bytes_remaining = remaining_dec;
            o_state.total_length    = i_state.total_length;
        end
    end

endmodule

[design/vsd_out_reg.sv]
// result register on the output stream, refilled while it is drained
module vsd_out_reg
    import vsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_result  i_result,
    input  logic     i_ready,
    output logic     o_valid,
    output logic     o_free,
    output t_result  o_result
);

    logic    r_valid;
    t_result r_result;

    // register can take a new result when empty or emptying this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

[design/varint_stream_decoder_core.sv]
// top level of the big-endian compact-size varint stream decoder
//
//  channel   direction  tdata                          tuser    tlast
//  s_axis    in         [7:0] data_byte                -        end_of_buffer
//  m_axis    out        [63:0] value, [67:64] length   status   -
//
// one byte is taken per cycle unless the output stalls; its result, if any, is shown
// on the next cycle from a single result register, so throughput is one byte per clock
// the decode state registers update only on an accepted byte
// reset (synchronous, active low) returns the decoder to idle and empties the output
// a stalled output holds its result and lowers s_axis_tready only while it is full
// and not being taken
module varint_stream_decoder_core
    import vsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,   // end_of_buffer
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [63:0] decoded_value,
                                                    // [67:64] encoded_length, [71:68] zero
    output logic                  o_m_axis_tuser    // status
);

    t_state  r_state;
    t_state  n_state;
    logic    step_emit;
    t_result step_result;
    t_result out_result;
    logic    out_free;
    logic    in_accept;

    assign o_s_axis_tready = out_free;
    assign in_accept       = i_s_axis_tvalid && out_free;

    // combinational decode of the incoming byte
    vsd_step u_step (
        .i_state         (r_state),
        .i_data_byte     (i_s_axis_tdata),
        .i_end_of_buffer (i_s_axis_tlast),
        .o_state         (n_state),
        .o_emit          (step_emit),
        .o_result        (step_result)
    );

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // output register
    vsd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_accept && step_emit),
        .i_result (step_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    // pack the output request
    assign o_m_axis_tdata = {4'd0, out_result.encoded_length, out_result.decoded_value};
    assign o_m_axis_tuser = out_result.status;

endmodule

[bench/tb_varint_stream_decoder_core.sv]
// self-checking testbench for the varint stream decoder top level
`timescale 1ns / 100ps

module tb_varint_stream_decoder_core;
    import vsd_pkg::*;

    localparam logic [7:0] PREFIX_EIGHT = 8'hff;
    localparam int         RESET_CYCLES = 12;
    localparam int         STALL_LIMIT  = 4000;
    localparam int         GAP_MAX      = 20;
    localparam int         DRAIN_CYCLES = 4;
    localparam int         DIRECTED_N   = 25;
    localparam int         RANDOM_N     = 1525;

    localparam t_result TRUNCATED = '{64'd0, 4'd0, STATUS_TRUNCATED};

    // one row of the directed stimulus; fixed rows carry their result typed in
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         fixed;
        t_result    result;
    } t_row;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'd0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // decoder state mirrored by the predictor
    logic [63:0] shadow_acc    = '0;
    logic [3:0]  shadow_remain = '0;
    logic [3:0]  shadow_total  = '0;

    t_result pending_results [$];
    t_row    dir_rows [DIRECTED_N];
    int      error_count   = 0;
    int      stall_cycles  = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    varint_stream_decoder_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    // clock generation
    always #4 clk = ~clk;

    // predictor: advance the mirrored state by one byte, report any result
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output t_result r);
        r = '0;
        if (shadow_remain == 4'd0) begin
            if (b < PREFIX_TWO) begin
                shadow_acc    = '0;
                shadow_total  = '0;
                r.decoded_value  = {56'd0, b};
                r.encoded_length = LENGTH_ONE;
                r.status         = STATUS_OK;
                return 1'b1;
            end
            shadow_acc = '0;
            case (b)
                PREFIX_TWO: begin
                    shadow_remain = PAYLOAD_TWO;
                    shadow_total  = LENGTH_THREE;
                end
                PREFIX_FOUR: begin
                    shadow_remain = PAYLOAD_FOUR;
                    shadow_total  = LENGTH_FIVE;
                end
                default: begin
                    shadow_remain = PAYLOAD_EIGHT;
                    shadow_total  = LENGTH_NINE;
                end
            endcase
        end else begin
            shadow_acc    = {shadow_acc[55:0], b};
            shadow_remain = shadow_remain - 4'd1;
            if (shadow_remain == 4'd0) begin
                r.decoded_value  = shadow_acc;
                r.encoded_length = shadow_total;
                r.status         = STATUS_OK;
                shadow_acc   = '0;
                shadow_total = '0;
                return 1'b1;
            end
        end
        // buffer ended while payload bytes are still owed
        if (last) begin
            shadow_acc    = '0;
            shadow_remain = '0;
            shadow_total  = '0;
            r = TRUNCATED;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // drive one request after a random gap and wait for its handshake
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit fixed, input t_result fixed_result);
        int      gap;
        t_result r;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        if (decode_byte(b, last, r) && !fixed) pending_results.push_back(r);
        if (fixed) pending_results.push_back(fixed_result);
    endtask

    // hold the sender off until every expected result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // random requests: mostly whole integers, some cut short, some noise
    task automatic run_random(input int count);
        int         sent;
        int         pick;
        int         plen;
        int         cut;
        logic [7:0] prefix;
        logic [7:0] b;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            case ($urandom_range(2))
                0: begin prefix = PREFIX_TWO;   plen = int'(PAYLOAD_TWO);   end
                1: begin prefix = PREFIX_FOUR;  plen = int'(PAYLOAD_FOUR);  end
                default: begin prefix = PREFIX_EIGHT; plen = int'(PAYLOAD_EIGHT); end
            endcase
            if (pick < 35) begin
                send_byte(8'($urandom_range(0, 8'hfc)), 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end else if (pick < 85) begin
                send_byte(prefix, 1'b0, 1'b0, '0);
                for (int i = 0; i < plen; i++) begin
                    case ($urandom_range(7))
                        0:       b = 8'h00;
                        1:       b = 8'hff;
                        default: b = 8'($urandom_range(255));
                    endcase
                    send_byte(b, (i == plen - 1) ? 1'($urandom_range(1)) : 1'b0, 1'b0, '0);
                end
                sent += plen + 1;
            end else if (pick < 95) begin
                // end of buffer lands on the prefix or inside the payload
                cut = $urandom_range(0, plen - 1);
                send_byte(prefix, cut == 0, 1'b0, '0);
                for (int i = 1; i <= cut; i++) begin
                    send_byte(8'($urandom_range(255)), i == cut, 1'b0, '0);
                end
                sent += cut + 1;
            end else begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end
        end
    endtask

    // receiver readiness
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk) begin
        t_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: value %h length %0d status %0d",
                       m_tdata[63:0], m_tdata[67:64], m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[63:0] !== want.decoded_value) begin
                    $error("decoded_value: expected %h, got %h",
                           want.decoded_value, m_tdata[63:0]);
                    error_count++;
                end
                if (m_tdata[67:64] !== want.encoded_length) begin
                    $error("encoded_length: expected %0d, got %0d",
                           want.encoded_length, m_tdata[67:64]);
                    error_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // main sequence
    initial begin
        dir_rows = '{
            // single bytes at both ends, end of buffer ignored
            '{8'h00, 1'b0, 1'b1, '{64'd0, LENGTH_ONE, STATUS_OK}},
            '{8'hfc, 1'b1, 1'b1, '{64'd252, LENGTH_ONE, STATUS_OK}},
            // each prefix with the buffer ending on the prefix itself
            '{8'hfd, 1'b1, 1'b1, TRUNCATED},
            '{8'hfe, 1'b1, 1'b1, TRUNCATED},
            '{8'hff, 1'b1, 1'b1, TRUNCATED},
            // two-byte payload ending exactly at the end of the buffer
            '{8'hfd, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b1, 1'b1, '{64'hffff, LENGTH_THREE, STATUS_OK}},
            // buffer ends inside a four-byte payload
            '{8'hfe, 1'b0, 1'b0, '0},
            '{8'hab, 1'b0, 1'b0, '0},
            '{8'hcd, 1'b1, 1'b1, TRUNCATED},
            // non-minimal four-byte encoding
            '{8'hfe, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0},
            '{8'h05, 1'b0, 1'b0, '0},
            // largest eight-byte value
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b0, '0},
            '{8'hff, 1'b0, 1'b1, '{64'hffff_ffff_ffff_ffff, LENGTH_NINE, STATUS_OK}}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, sender slow and receiver mostly stalled
        send_idle_pct = 29;
        recv_idle_pct = 71;
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].fixed,
                      dir_rows[i].result);
        end
        drain_results();

        run_random(RANDOM_N / 3);
        drain_results();

        send_idle_pct = 71;
        recv_idle_pct = 29;
        run_random(RANDOM_N / 3);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_N - 2 * (RANDOM_N / 3));
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/vsd_pkg.sv
design/vsd_step.sv
design/vsd_out_reg.sv
design/varint_stream_decoder_core.sv
bench/tb_varint_stream_decoder_core.sv
